// ----- sv/spfu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spanning forest package
// Widths, row layout of the label and size memories, codes and helpers.
// ----------------------------------------------------------------------------
package spfu_pkg;

   localparam int MaxVertices = 1024;
   localparam int VtxW        = $clog2(MaxVertices);
   localparam int CntW        = VtxW + 1;
   localparam int SizeW       = CntW;
   localparam int WeightW     = 32;
   localparam int StatusW     = 2;
   localparam int LaneW       = 4;
   localparam int Lanes       = 1 << LaneW;
   localparam int RowW        = VtxW - LaneW;
   localparam int RowCount    = MaxVertices / Lanes;
   localparam int StepW       = RowW + 1;
   localparam int LabelRowW   = Lanes * VtxW;
   localparam int SizeRowW    = Lanes * SizeW;

   localparam logic OpEdge  = 1'b0;
   localparam logic OpClear = 1'b1;

   typedef enum logic [StatusW-1:0] {
      STATUS_TAKEN = 2'd0,
      STATUS_SAME  = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_LABEL,
      ST_SIZE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef logic [Lanes-1:0][VtxW-1:0]  label_row_type;
   typedef logic [Lanes-1:0][SizeW-1:0] size_row_type;

   // merge command for the row relabel unit
   typedef struct packed {
      logic [VtxW-1:0] from_label;
      logic [VtxW-1:0] to_label;
   } relabel_cmd_type;

   function automatic label_row_type init_label_row(input logic [RowW-1:0] row);
      label_row_type r;
      for (int j = 0; j < Lanes; j++) begin
         r[j] = {row, LaneW'(j)};
      end
      return r;
   endfunction

   function automatic size_row_type init_size_row();
      size_row_type r;
      for (int j = 0; j < Lanes; j++) begin
         r[j] = SizeW'(1);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- sv/spfu_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module spfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr0,
   output logic      [WIDTH-1:0]         rd_data0,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr1,
   output logic      [WIDTH-1:0]         rd_data1
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
   end

endmodule
`default_nettype wire

// ----- sv/spfu_relabel.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Row relabel unit
// Replace every label of one memory row that matches the merged-away label.
// ----------------------------------------------------------------------------
module spfu_relabel (
   input  wire spfu_pkg::label_row_type   row_in,
   input  wire spfu_pkg::relabel_cmd_type cmd,
   output spfu_pkg::label_row_type        row_out
);
   import spfu_pkg::*;

   always_comb begin
      for (int j = 0; j < Lanes; j++) begin
         row_out[j] = (row_in[j] == cmd.from_label) ? cmd.to_label : row_in[j];
      end
   end

endmodule
`default_nettype wire

// ----- sv/spanning_forest_union_by_size.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spanning forest builder, quick-find with union by size
// Steps: a merging edge reads both label rows, then both size rows, then
//   scans; a rejected edge is answered straight away (vertex out of range
//   or tree complete) or after the label read (same component). One item
//   in flight; the next word is taken the cycle after the result word loads.
// Throughput is set by the relabel scan: 64 label rows of 16 labels, one row
//   read and written back per cycle through the shared row relabel unit.
// Reset (synchronous, active high) runs a clearing pass over both
//   memories; req_stall stays high until it is done.
// ----------------------------------------------------------------------------
module spanning_forest_union_by_size (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // configuration
   input  wire logic                          csr_wr_en,
   input  wire logic [spfu_pkg::CntW-1:0]     csr_wr_data,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_operation,
   input  wire logic [spfu_pkg::VtxW-1:0]     req_end_a,
   input  wire logic [spfu_pkg::VtxW-1:0]     req_end_b,
   input  wire logic [spfu_pkg::WeightW-1:0]  req_edge_weight,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [spfu_pkg::StatusW-1:0]       rsp_status,
   output logic [spfu_pkg::VtxW-1:0]          rsp_tree_small_end,
   output logic [spfu_pkg::VtxW-1:0]          rsp_tree_large_end,
   output logic [spfu_pkg::WeightW-1:0]       rsp_tree_weight,
   output logic [spfu_pkg::VtxW-1:0]          rsp_tree_index,
   output logic [spfu_pkg::CntW-1:0]          rsp_components_left
);
   import spfu_pkg::*;

   // sequencer
   state_type           state_ff, state_in;
   logic [StepW-1:0]    cnt_ff, cnt_in;

   // control registers
   logic [CntW-1:0]     vcount_ff, vcount_in;
   logic [CntW-1:0]     remaining_ff, remaining_in;
   logic [VtxW-1:0]     tree_cnt_ff, tree_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // item payload held while the item is at work
   logic [VtxW-1:0]     end_a_ff, end_a_in;
   logic [VtxW-1:0]     end_b_ff, end_b_in;
   logic [WeightW-1:0]  weight_ff, weight_in;
   logic [VtxW-1:0]     la_ff, la_in;
   logic [VtxW-1:0]     lb_ff, lb_in;
   logic                swap_ff, swap_in;
   status_type          status_ff, status_in;
   logic [VtxW-1:0]     index_ff, index_in;

   // response word
   status_type          rsp_status_ff, rsp_status_in;
   logic [VtxW-1:0]     rsp_small_ff, rsp_small_in;
   logic [VtxW-1:0]     rsp_large_ff, rsp_large_in;
   logic [WeightW-1:0]  rsp_weight_ff, rsp_weight_in;
   logic [VtxW-1:0]     rsp_index_ff, rsp_index_in;
   logic [CntW-1:0]     rsp_left_ff, rsp_left_in;

   // memories
   logic                lbl_we;
   logic [RowW-1:0]     lbl_waddr, lbl_raddr0, lbl_raddr1;
   label_row_type       lbl_wdata, lbl_rdata0, lbl_rdata1;
   logic                siz_we;
   logic [RowW-1:0]     siz_waddr, siz_raddr0, siz_raddr1;
   size_row_type        siz_wdata, siz_rdata0, siz_rdata1;

   // shared units
   relabel_cmd_type     relabel_cmd;
   label_row_type       relabel_row;

   // decoded values
   logic [CntW-1:0]     eff_count;
   logic                accept;
   logic                range_bad;
   logic [VtxW-1:0]     la_cur, lb_cur;
   logic [SizeW-1:0]    size_a, size_b, size_sum;
   logic                size_swap;
   logic                rsp_load;
   logic                sweep_last;
   logic                scan_last;

   // effective vertex count: register clamped into [2, MaxVertices]
   always_comb begin
      if (vcount_ff < CntW'(2)) begin
         eff_count = CntW'(2);
      end else if (vcount_ff > CntW'(MaxVertices)) begin
         eff_count = CntW'(MaxVertices);
      end else begin
         eff_count = vcount_ff;
      end
   end

   assign accept     = req_valid && !req_stall;
   assign range_bad  = (CntW'(req_end_a) >= eff_count) || (CntW'(req_end_b) >= eff_count);
   assign sweep_last = (cnt_ff == StepW'(RowCount - 1));
   assign scan_last  = (cnt_ff == StepW'(RowCount));
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // labels of both ends, read in the cycle after the label rows were addressed
   assign la_cur = lbl_rdata0[end_a_ff[LaneW-1:0]];
   assign lb_cur = lbl_rdata1[end_b_ff[LaneW-1:0]];

   // compare and add unit on the two component sizes
   assign size_a    = siz_rdata0[la_ff[LaneW-1:0]];
   assign size_b    = siz_rdata1[lb_ff[LaneW-1:0]];
   assign size_swap = (size_b < size_a);
   assign size_sum  = size_a + size_b;

   // the scan folds the label of the smaller component into the larger one's
   assign relabel_cmd.from_label = swap_ff ? lb_ff : la_ff;
   assign relabel_cmd.to_label   = swap_ff ? la_ff : lb_ff;

   spfu_relabel u_relabel (
      .row_in  (lbl_rdata0),
      .cmd     (relabel_cmd),
      .row_out (relabel_row)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OpClear) begin
                  state_in = ST_CLEAR;
               end else if (range_bad || remaining_ff <= CntW'(1)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_LABEL;
               end
            end
         end
         ST_CLEAR: begin
            if (sweep_last) begin
               state_in = ST_DONE;
            end
         end
         ST_LABEL: begin
            state_in = (la_cur == lb_cur) ? ST_DONE : ST_SIZE;
         end
         ST_SIZE: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // memory control and handshake outputs
   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      lbl_we     = 1'b0;
      lbl_waddr  = cnt_ff[RowW-1:0];
      lbl_wdata  = init_label_row(cnt_ff[RowW-1:0]);
      lbl_raddr0 = req_end_a[VtxW-1:LaneW];
      lbl_raddr1 = req_end_b[VtxW-1:LaneW];
      siz_we     = 1'b0;
      siz_waddr  = cnt_ff[RowW-1:0];
      siz_wdata  = init_size_row();
      siz_raddr0 = la_cur[VtxW-1:LaneW];
      siz_raddr1 = lb_cur[VtxW-1:LaneW];
      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            // write singleton rows, one row a cycle
            lbl_we = 1'b1;
            siz_we = 1'b1;
         end
         ST_SIZE: begin
            // write the summed size into the row of the surviving label
            siz_we = 1'b1;
            if (size_swap) begin
               siz_waddr = la_ff[VtxW-1:LaneW];
               siz_wdata = siz_rdata0;
               siz_wdata[la_ff[LaneW-1:0]] = size_sum;
            end else begin
               siz_waddr = lb_ff[VtxW-1:LaneW];
               siz_wdata = siz_rdata1;
               siz_wdata[lb_ff[LaneW-1:0]] = size_sum;
            end
         end
         ST_SCAN: begin
            // read row cnt, write back row cnt-1 through the relabel unit
            lbl_raddr0 = cnt_ff[RowW-1:0];
            lbl_we     = (cnt_ff != '0);
            lbl_waddr  = cnt_ff[RowW-1:0] - RowW'(1);
            lbl_wdata  = relabel_row;
         end
         default: begin
         end
      endcase
   end

   // register next values
   always_comb begin
      cnt_in        = (state_in == state_ff) ? cnt_ff + StepW'(1) : '0;
      vcount_in     = csr_wr_en ? csr_wr_data : vcount_ff;
      remaining_in  = remaining_ff;
      tree_cnt_in   = tree_cnt_ff;
      end_a_in      = end_a_ff;
      end_b_in      = end_b_ff;
      weight_in     = weight_ff;
      la_in         = la_ff;
      lb_in         = lb_ff;
      swap_in       = swap_ff;
      status_in     = status_ff;
      index_in      = index_ff;
      rsp_valid_in  = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_status_in = rsp_status_ff;
      rsp_small_in  = rsp_small_ff;
      rsp_large_in  = rsp_large_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_left_in   = rsp_left_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               end_a_in  = req_end_a;
               end_b_in  = req_end_b;
               weight_in = req_edge_weight;
               status_in = range_bad ? STATUS_RANGE : STATUS_FULL;
            end
         end
         ST_CLEAR: begin
            if (sweep_last) begin
               remaining_in = eff_count;
               tree_cnt_in  = '0;
               status_in    = STATUS_FULL;
            end
         end
         ST_LABEL: begin
            la_in     = la_cur;
            lb_in     = lb_cur;
            status_in = STATUS_SAME;
         end
         ST_SIZE: begin
            swap_in = size_swap;
         end
         ST_SCAN: begin
            if (scan_last) begin
               status_in    = STATUS_TAKEN;
               index_in     = tree_cnt_ff;
               tree_cnt_in  = tree_cnt_ff + VtxW'(1);
               remaining_in = remaining_ff - CntW'(1);
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_status_in = status_ff;
               rsp_left_in   = remaining_ff;
               if (status_ff == STATUS_TAKEN) begin
                  rsp_small_in  = swap_ff ? end_b_ff : end_a_ff;
                  rsp_large_in  = swap_ff ? end_a_ff : end_b_ff;
                  rsp_weight_in = weight_ff;
                  rsp_index_in  = index_ff;
               end else begin
                  rsp_small_in  = '0;
                  rsp_large_in  = '0;
                  rsp_weight_in = '0;
                  rsp_index_in  = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         vcount_ff    <= CntW'(MaxVertices);
         remaining_ff <= CntW'(MaxVertices);
         tree_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         vcount_ff    <= vcount_in;
         remaining_ff <= remaining_in;
         tree_cnt_ff  <= tree_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      end_a_ff      <= end_a_in;
      end_b_ff      <= end_b_in;
      weight_ff     <= weight_in;
      la_ff         <= la_in;
      lb_ff         <= lb_in;
      swap_ff       <= swap_in;
      status_ff     <= status_in;
      index_ff      <= index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_small_ff  <= rsp_small_in;
      rsp_large_ff  <= rsp_large_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_left_ff   <= rsp_left_in;
   end

   // label memory: 64 rows of 16 labels
   spfu_ram #(
      .WIDTH (LabelRowW),
      .DEPTH (RowCount)
   ) u_label_ram (
      .clock    (clock),
      .wr_en    (lbl_we),
      .wr_addr  (lbl_waddr),
      .wr_data  (lbl_wdata),
      .rd_addr0 (lbl_raddr0),
      .rd_data0 (lbl_rdata0),
      .rd_addr1 (lbl_raddr1),
      .rd_data1 (lbl_rdata1)
   );

   // size memory: 64 rows of 16 sizes, indexed by label
   spfu_ram #(
      .WIDTH (SizeRowW),
      .DEPTH (RowCount)
   ) u_size_ram (
      .clock    (clock),
      .wr_en    (siz_we),
      .wr_addr  (siz_waddr),
      .wr_data  (siz_wdata),
      .rd_addr0 (siz_raddr0),
      .rd_data0 (siz_rdata0),
      .rd_addr1 (siz_raddr1),
      .rd_data1 (siz_rdata1)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_tree_small_end  = rsp_small_ff;
   assign rsp_tree_large_end  = rsp_large_ff;
   assign rsp_tree_weight     = rsp_weight_ff;
   assign rsp_tree_index      = rsp_index_ff;
   assign rsp_components_left = rsp_left_ff;

endmodule
`default_nettype wire

// ----- sv/spfu_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spanning forest port checker
// Watches the top level ports and flags inconsistent result words.
// ----------------------------------------------------------------------------
module spfu_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [spfu_pkg::StatusW-1:0]  rsp_status,
   input  wire logic [spfu_pkg::VtxW-1:0]     rsp_tree_small_end,
   input  wire logic [spfu_pkg::VtxW-1:0]     rsp_tree_large_end,
   input  wire logic [spfu_pkg::WeightW-1:0]  rsp_tree_weight,
   input  wire logic [spfu_pkg::VtxW-1:0]     rsp_tree_index,
   input  wire logic [spfu_pkg::CntW-1:0]     rsp_components_left
);
   import spfu_pkg::*;

   // a stalled result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // one item at a time: the cycle after an accept the block is busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted while an item is at work");

   // rejected words carry no tree edge
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_TAKEN |->
         rsp_tree_small_end == '0 && rsp_tree_large_end == '0 &&
         rsp_tree_weight == '0 && rsp_tree_index == '0)
      else $error("rejected word carries tree fields");

   // a tree edge joins two distinct vertices
   a_taken_distinct: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_TAKEN |->
         rsp_tree_small_end != rsp_tree_large_end)
      else $error("tree edge is a self loop");

   // at least one and at most all vertices remain as components
   a_left_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_components_left != '0 &&
         rsp_components_left <= CntW'(MaxVertices))
      else $error("component count out of range");

endmodule

bind spanning_forest_union_by_size spfu_checker u_spfu_checker (.*);
`default_nettype wire
